/* src/alr_pkg.sv */
// ----------------------------------------------------------------------------
// alr_pkg: shared types and constants for the adaptive linear resampler
// Word layout, item control bundle, default parameters, step scale factors.
// ----------------------------------------------------------------------------
package alr_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TUSER_W  = 2;

    localparam int DEF_RING_DEPTH = 4096;
    localparam int DEF_LOW_WATER  = 1024;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int INT_BITS = 4;

    localparam int SCALE_UP   = 101;
    localparam int SCALE_DOWN = 99;
    localparam int SCALE_DIV  = 100;

    localparam int OUT_DEPTH = 8;

    localparam logic ACT_PUSH   = 1'b0;
    localparam logic ACT_RENDER = 1'b1;

    localparam int TU_ACTION   = 0;
    localparam int TU_BATCH    = 1;
    localparam int TU_UNDERRUN = 0;
    localparam int TU_DROPPED  = 1;

    typedef struct packed {
        logic valid;
        logic interp;
        logic underrun;
        logic dropped;
    } t_item_ctl;

    typedef struct packed {
        logic [TUSER_W-1:0]  user;
        logic [SAMPLE_W-1:0] data;
    } t_out_word;

endpackage

/* src/alr_ram.sv */
// ----------------------------------------------------------------------------
// alr_ram: single-port synchronous RAM
// One access per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
module alr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/alr_step_calc.sv */
// ----------------------------------------------------------------------------
// alr_step_calc: base step register and scaled step precompute
// Holds base_step and derives base*1.01 and base*0.99 in registered stages.
// ----------------------------------------------------------------------------
module alr_step_calc #(
    parameter int FRAC_BITS = alr_pkg::DEF_FRAC_BITS,
    localparam int STEP_W = alr_pkg::INT_BITS + FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  logic [STEP_W-1:0] i_wdata,
    output logic [STEP_W-1:0] o_base,
    output logic [STEP_W-1:0] o_step_up,
    output logic [STEP_W-1:0] o_step_dn,
    output logic              o_busy
);

    import alr_pkg::*;

    localparam int PROD_W  = STEP_W + 7;
    localparam int QUO_W   = STEP_W + 1;
    localparam int RECIP_W = PROD_W - 6;
    localparam int MUL_W   = PROD_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL = (64'd1 << PROD_W) / 64'(SCALE_DIV);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
    localparam logic [STEP_W-1:0] STEP_MAX = '1;
    localparam logic [STEP_W-1:0] ONE_STEP = STEP_W'(1) << FRAC_BITS;
    localparam logic [1:0] CAL_CYCLES = 2'd3;

    logic [STEP_W-1:0] r_base;
    logic [1:0]        r_cnt;
    logic [PROD_W-1:0] r_p_up;
    logic [PROD_W-1:0] r_p_dn;
    logic [MUL_W-1:0]  r_m_up;
    logic [MUL_W-1:0]  r_m_dn;
    logic [STEP_W-1:0] r_step_up;
    logic [STEP_W-1:0] r_step_dn;
    logic [STEP_W-1:0] n_step_up;
    logic [STEP_W-1:0] n_step_dn;

    function automatic logic [STEP_W-1:0] fix_quot(input logic [PROD_W-1:0] p,
                                                   input logic [MUL_W-1:0] m);
        logic [QUO_W-1:0]  q;
        logic [PROD_W-1:0] rem;
        q   = QUO_W'(m >> PROD_W);
        rem = p - PROD_W'(q) * PROD_W'(SCALE_DIV);
        if (rem >= PROD_W'(SCALE_DIV)) begin
            q = q + QUO_W'(1);
        end
        if (q > QUO_W'(STEP_MAX)) begin
            return STEP_MAX;
        end
        return q[STEP_W-1:0];
    endfunction

    always_comb begin
        n_step_up = fix_quot(r_p_up, r_m_up);
        n_step_dn = fix_quot(r_p_dn, r_m_dn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= ONE_STEP;
            r_cnt  <= CAL_CYCLES;
        end else if (i_wr) begin
            r_base <= i_wdata;
            r_cnt  <= CAL_CYCLES;
        end else if (r_cnt != 2'd0) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_up    <= PROD_W'(r_base) * PROD_W'(SCALE_UP);
        r_p_dn    <= PROD_W'(r_base) * PROD_W'(SCALE_DOWN);
        r_m_up    <= MUL_W'(r_p_up) * MUL_W'(RECIP);
        r_m_dn    <= MUL_W'(r_p_dn) * MUL_W'(RECIP);
        r_step_up <= n_step_up;
        r_step_dn <= n_step_dn;
    end

    assign o_base    = r_base;
    assign o_step_up = r_step_up;
    assign o_step_dn = r_step_dn;
    assign o_busy    = (r_cnt != 2'd0);

endmodule

/* src/alr_interp.sv */
// ----------------------------------------------------------------------------
// alr_interp: interpolation pipeline and output queue
// Captures the two ring reads, multiplies, rounds toward zero, queues words.
// ----------------------------------------------------------------------------
module alr_interp #(
    parameter int FRAC_BITS = alr_pkg::DEF_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  alr_pkg::t_item_ctl           i_ctl,
    input  logic [FRAC_BITS-1:0]         i_pos,
    input  logic [alr_pkg::SAMPLE_W-1:0] i_rdata,
    output logic                         o_tvalid,
    input  logic                         i_tready,
    output logic [alr_pkg::SAMPLE_W-1:0] o_tdata,
    output logic [alr_pkg::TUSER_W-1:0]  o_tuser
);

    import alr_pkg::*;

    localparam int PROD_W = SAMPLE_W + FRAC_BITS + 2;
    localparam int PTR_W  = $clog2(OUT_DEPTH);
    localparam logic [PROD_W-1:0] BIAS = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);

    t_item_ctl                  r1_ctl;
    t_item_ctl                  r2_ctl;
    t_item_ctl                  r3_ctl;
    logic [FRAC_BITS-1:0]       r1_pos;
    logic [FRAC_BITS-1:0]       r2_pos;
    logic [SAMPLE_W-1:0]        r2_a;
    logic [SAMPLE_W-1:0]        r3_a;
    logic signed [PROD_W-1:0]   r3_prod;
    logic [SAMPLE_W-1:0]        r_held;
    t_out_word                  r_fifo [OUT_DEPTH];
    logic [PTR_W:0]             r_wp;
    logic [PTR_W:0]             r_rp;

    logic signed [SAMPLE_W:0]   w_diff;
    logic signed [FRAC_BITS:0]  w_posx;
    logic signed [PROD_W-1:0]   w_shift;
    logic [SAMPLE_W-1:0]        w_interp;
    t_out_word                  w_word;

    always_comb begin
        w_diff  = $signed({i_rdata[SAMPLE_W-1], i_rdata}) - $signed({r2_a[SAMPLE_W-1], r2_a});
        w_posx  = $signed({1'b0, r2_pos});
        w_shift = (r3_prod + $signed(r3_prod[PROD_W-1] ? BIAS : '0)) >>> FRAC_BITS;
        w_interp = r3_a + w_shift[SAMPLE_W-1:0];
        w_word.user = '0;
        w_word.user[TU_UNDERRUN] = r3_ctl.underrun;
        w_word.user[TU_DROPPED]  = r3_ctl.dropped;
        if (r3_ctl.interp) begin
            w_word.data = w_interp;
        end else if (r3_ctl.underrun) begin
            w_word.data = r_held;
        end else begin
            w_word.data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r_held <= '0;
            r_wp   <= '0;
            r_rp   <= '0;
        end else begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= r2_ctl;
            if (r3_ctl.valid) begin
                r_wp <= r_wp + (PTR_W + 1)'(1);
            end
            if (r3_ctl.valid && r3_ctl.interp) begin
                r_held <= w_interp;
            end
            if (o_tvalid && i_tready) begin
                r_rp <= r_rp + (PTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_pos  <= i_pos;
        r2_pos  <= r1_pos;
        r2_a    <= i_rdata;
        r3_a    <= r2_a;
        r3_prod <= w_diff * w_posx;
        if (r3_ctl.valid) begin
            r_fifo[r_wp[PTR_W-1:0]] <= w_word;
        end
    end

    assign o_tvalid = (r_wp != r_rp);
    assign o_tdata  = r_fifo[r_rp[PTR_W-1:0]].data;
    assign o_tuser  = r_fifo[r_rp[PTR_W-1:0]].user;

endmodule

/* src/adaptive_linear_resampler_core.sv */
// ----------------------------------------------------------------------------
// adaptive_linear_resampler_core: ring buffer linear interpolating resampler
// A result word passes registers r1, r2, r3 and the output queue. Push 1 word
// per cycle unless the input stalls: while OUT_DEPTH words are in flight, after
// reset and after each base_step write, and while an interpolating render's
// second read of the single-port sample ring is pending. Reset: indices and
// position clear, step is 1.0; ring contents stay as they were.
// ----------------------------------------------------------------------------
module adaptive_linear_resampler_core #(
    parameter int RING_DEPTH = alr_pkg::DEF_RING_DEPTH,
    parameter int LOW_WATER  = alr_pkg::DEF_LOW_WATER,
    parameter int FRAC_BITS  = alr_pkg::DEF_FRAC_BITS,
    localparam int STEP_W = alr_pkg::INT_BITS + FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  logic [alr_pkg::SAMPLE_W-1:0] i_s_axis_tdata,  // [15:0] sample
    input  logic [alr_pkg::TUSER_W-1:0]  i_s_axis_tuser,  // [0] action, [1] batch_start
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    output logic [alr_pkg::SAMPLE_W-1:0] o_m_axis_tdata,  // [15:0] out_sample
    output logic [alr_pkg::TUSER_W-1:0]  o_m_axis_tuser,  // [0] underrun, [1] dropped
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [STEP_W-1:0]            i_cfg_data
);

    import alr_pkg::*;

    localparam int IDX_W   = $clog2(RING_DEPTH);
    localparam int SUM_W   = STEP_W + 1;
    localparam int WHOLE_W = SUM_W - FRAC_BITS;
    localparam int CNT_W   = $clog2(OUT_DEPTH + 1);
    localparam logic [IDX_W:0]    DEPTH_X  = (IDX_W + 1)'(RING_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(RING_DEPTH - 1);
    localparam logic [STEP_W-1:0] ONE_STEP = STEP_W'(1) << FRAC_BITS;

    logic [IDX_W-1:0]     r_wr_idx;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [FRAC_BITS-1:0] r_pos;
    logic [STEP_W-1:0]    r_step;
    logic                 r_b_pending;
    logic [IDX_W-1:0]     r_addr_b;
    logic [CNT_W-1:0]     r_count;

    logic [STEP_W-1:0]    w_base;
    logic [STEP_W-1:0]    w_step_up;
    logic [STEP_W-1:0]    w_step_dn;
    logic                 w_cal_busy;
    logic                 w_accept;
    logic                 w_pop;
    logic                 w_action;
    logic                 w_batch;
    logic [IDX_W:0]       w_diff;
    logic [IDX_W-1:0]     w_fill;
    logic                 w_full;
    logic                 w_underrun;
    logic [STEP_W-1:0]    w_step_eff;
    logic [SUM_W-1:0]     w_sum;
    logic [WHOLE_W-1:0]   w_whole;
    logic [IDX_W-1:0]     w_whole_x;
    logic [IDX_W-1:0]     w_avail;
    logic                 w_fits;
    logic [IDX_W-1:0]     w_adv;
    logic [IDX_W:0]       w_rd_sum;
    logic [IDX_W-1:0]     w_rd_next;
    logic [IDX_W-1:0]     w_rd_plus1;
    logic [IDX_W-1:0]     w_wr_next;
    logic                 w_do_write;
    logic                 w_do_read;
    logic [IDX_W-1:0]     w_addr;
    logic [SAMPLE_W-1:0]  w_rdata;
    t_item_ctl            w_ctl;

    alr_step_calc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_step_calc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (i_cfg_valid && o_cfg_ready),
        .i_wdata   (i_cfg_data),
        .o_base    (w_base),
        .o_step_up (w_step_up),
        .o_step_dn (w_step_dn),
        .o_busy    (w_cal_busy)
    );

    always_comb begin
        w_accept = i_s_axis_tvalid && o_s_axis_tready;
        w_pop    = o_m_axis_tvalid && i_m_axis_tready;
        w_action = i_s_axis_tuser[TU_ACTION];
        w_batch  = i_s_axis_tuser[TU_BATCH];

        w_diff = {1'b0, r_wr_idx} - {1'b0, r_rd_idx};
        w_fill = w_diff[IDX_W] ? IDX_W'(w_diff + DEPTH_X) : w_diff[IDX_W-1:0];
        w_full = (w_fill == LAST_IDX);
        w_underrun = (w_fill < IDX_W'(2));

        if (!w_batch) begin
            w_step_eff = r_step;
        end else if ({1'b0, w_fill} > (DEPTH_X >> 1)) begin
            w_step_eff = w_step_up;
        end else if (32'(w_fill) < LOW_WATER) begin
            w_step_eff = w_step_dn;
        end else begin
            w_step_eff = w_base;
        end

        w_sum     = SUM_W'(r_pos) + SUM_W'(w_step_eff);
        w_whole   = w_sum[SUM_W-1:FRAC_BITS];
        w_whole_x = {{(IDX_W - WHOLE_W){1'b0}}, w_whole};
        w_avail   = w_fill - IDX_W'(1);
        w_fits    = (w_whole_x <= w_avail);
        w_adv     = w_fits ? w_whole_x : w_avail;
        w_rd_sum  = {1'b0, r_rd_idx} + {1'b0, w_adv};
        w_rd_next = (w_rd_sum >= DEPTH_X) ? IDX_W'(w_rd_sum - DEPTH_X) : w_rd_sum[IDX_W-1:0];
        w_rd_plus1 = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + IDX_W'(1);
        w_wr_next  = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + IDX_W'(1);

        w_do_write = w_accept && (w_action == ACT_PUSH) && !w_full;
        w_do_read  = w_accept && (w_action == ACT_RENDER) && !w_underrun;

        if (r_b_pending) begin
            w_addr = r_addr_b;
        end else if (w_do_write) begin
            w_addr = r_wr_idx;
        end else begin
            w_addr = r_rd_idx;
        end

        w_ctl.valid    = w_accept;
        w_ctl.interp   = w_do_read;
        w_ctl.underrun = w_accept && (w_action == ACT_RENDER) && w_underrun;
        w_ctl.dropped  = w_accept && (w_action == ACT_PUSH) && w_full;
    end

    alr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_do_write),
        .i_re    (w_do_read || r_b_pending),
        .i_addr  (w_addr),
        .i_wdata (i_s_axis_tdata),
        .o_rdata (w_rdata)
    );

    alr_interp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_pos    (r_pos),
        .i_rdata  (w_rdata),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_pos       <= '0;
            r_step      <= ONE_STEP;
            r_b_pending <= 1'b0;
            r_count     <= '0;
        end else begin
            r_b_pending <= w_do_read;
            r_count     <= r_count + CNT_W'(w_accept) - CNT_W'(w_pop);
            if (w_do_read) begin
                r_addr_b <= w_rd_plus1;
                r_rd_idx <= w_rd_next;
                r_pos    <= w_fits ? w_sum[FRAC_BITS-1:0] : '0;
            end
            if (w_do_write) begin
                r_wr_idx <= w_wr_next;
            end
            if (w_accept && (w_action == ACT_RENDER) && w_batch) begin
                r_step <= w_step_eff;
            end
        end
    end

    assign o_s_axis_tready = !w_cal_busy && !r_b_pending && (r_count < CNT_W'(OUT_DEPTH));
    assign o_cfg_ready     = 1'b1;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(OUT_DEPTH))
        else $error("words in flight exceed output queue depth");

    a_second_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_read |=> (r_b_pending && !o_s_axis_tready))
        else $error("input taken while second ring read pending");

    a_drop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_action == ACT_PUSH) && w_full) |=> $stable(r_wr_idx))
        else $error("write index moved on a dropped push");

    a_out_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_count != '0))
        else $error("output word with no accepted input");

    a_fill_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, w_fill} < DEPTH_X)
        else $error("ring fill out of range");

endmodule

/* tb/tb_adaptive_linear_resampler_core.sv */
// ----------------------------------------------------------------------------
// tb_adaptive_linear_resampler_core: self-checking bench for the resampler core
// Drives push and render words on the input stream and predicts every output
// word: ring fill, step reload from base_step, truncating interpolation and
// position advance, underrun hold and full-ring drop. A short directed table
// runs first, then batches of random traffic under several base_step settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_adaptive_linear_resampler_core;
    import alr_pkg::*;

    localparam int FB             = DEF_FRAC_BITS;
    localparam int STEP_W         = INT_BITS + FB;
    localparam int RING           = DEF_RING_DEPTH;
    localparam int ONE_POS        = 1 << FB;
    localparam int STEP_MAX       = (1 << STEP_W) - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int N_DIR          = 20;
    localparam int N_PHASE        = 9;
    localparam int PHASE_ITEMS    = 55;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                under;
        logic                drop;
    } t_out_exp;

    typedef struct packed {
        logic                act;
        logic [SAMPLE_W-1:0] smp;
        logic                bat;
        logic                typed;
        t_out_exp            word;
    } t_dir_row;

    localparam t_out_exp ZERO_WORD  = '{16'h0000, 1'b0, 1'b0};
    localparam t_out_exp UNDER_ZERO = '{16'h0000, 1'b1, 1'b0};

    localparam t_dir_row DIR_ROWS [0:N_DIR-1] = '{
        '{ACT_RENDER, 16'h0000, 1'b1, 1'b1, UNDER_ZERO},
        '{ACT_RENDER, 16'h0000, 1'b0, 1'b1, UNDER_ZERO},
        '{ACT_PUSH,   16'h7FFF, 1'b0, 1'b1, ZERO_WORD},
        '{ACT_RENDER, 16'h0000, 1'b1, 1'b1, UNDER_ZERO},
        '{ACT_PUSH,   16'h8000, 1'b1, 1'b1, ZERO_WORD},
        '{ACT_PUSH,   16'h0000, 1'b0, 1'b1, ZERO_WORD},
        '{ACT_PUSH,   16'h0001, 1'b0, 1'b1, ZERO_WORD},
        '{ACT_PUSH,   16'hFFFF, 1'b0, 1'b1, ZERO_WORD},
        '{ACT_PUSH,   16'hA5A5, 1'b0, 1'b1, ZERO_WORD},
        '{ACT_RENDER, 16'hFFFF, 1'b0, 1'b1, '{16'h7FFF, 1'b0, 1'b0}},
        '{ACT_RENDER, 16'h0000, 1'b0, 1'b0, ZERO_WORD},
        '{ACT_RENDER, 16'h0000, 1'b1, 1'b0, ZERO_WORD},
        '{ACT_RENDER, 16'h5A5A, 1'b0, 1'b0, ZERO_WORD},
        '{ACT_RENDER, 16'h0000, 1'b0, 1'b0, ZERO_WORD},
        '{ACT_RENDER, 16'h0000, 1'b0, 1'b0, ZERO_WORD},
        '{ACT_RENDER, 16'h0000, 1'b0, 1'b0, ZERO_WORD},
        '{ACT_RENDER, 16'h0000, 1'b1, 1'b0, ZERO_WORD},
        '{ACT_PUSH,   16'h7FFF, 1'b0, 1'b1, ZERO_WORD},
        '{ACT_RENDER, 16'h0000, 1'b1, 1'b0, ZERO_WORD},
        '{ACT_RENDER, 16'h0000, 1'b0, 1'b0, ZERO_WORD}
    };

    localparam int PHASE_STEP [0:N_PHASE-1] = '{
        1, STEP_MAX, 0, ONE_POS, 0, 32768, 0, 65535, 98304
    };

    logic                i_clk;
    logic                i_rst_n   = 1'b0;
    logic                s_valid   = 1'b0;
    logic [SAMPLE_W-1:0] s_data    = '0;
    logic [TUSER_W-1:0]  s_user    = '0;
    logic                m_ready   = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [STEP_W-1:0]   cfg_data  = '0;
    logic                s_ready;
    logic                m_valid;
    logic [SAMPLE_W-1:0] m_data;
    logic [TUSER_W-1:0]  m_user;
    logic                cfg_ready;

    logic [SAMPLE_W-1:0] ring_copy [0:RING-1];
    int                  wr_ptr;
    int                  rd_ptr;
    int                  frac_pos;
    int                  step_now;
    int                  base_step_reg;
    logic [SAMPLE_W-1:0] held_smp;

    t_out_exp out_word_q [$];

    int s_idle_pct   = 0;
    int r_idle_pct   = 0;
    int n_errors     = 0;
    int n_sent       = 0;
    int n_checked    = 0;
    int n_underruns  = 0;
    int n_drops      = 0;
    int n_cfg_writes = 0;
    int stall_cycles = 0;

    adaptive_linear_resampler_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),   // [15:0] sample
        .i_s_axis_tuser  (s_user),   // [0] action, [1] batch_start
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),   // [15:0] out_sample
        .o_m_axis_tuser  (m_user),   // [0] underrun, [1] dropped
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int fill_now();
        return (wr_ptr + RING - rd_ptr) % RING;
    endfunction

    function automatic t_out_exp predict_word(input logic act, input logic [SAMPLE_W-1:0] smp,
                                              input logic bat);
        t_out_exp res;
        int       fill;
        int       a;
        int       b;
        int       r;
        int       acc;
        int       whole;
        int       avail;
        longint   s;
        longint   prod;
        longint   t;
        res  = ZERO_WORD;
        fill = fill_now();
        if (act == ACT_PUSH) begin
            if (fill >= RING - 1) begin
                res.drop = 1'b1;
            end else begin
                ring_copy[wr_ptr] = smp;
                wr_ptr = (wr_ptr + 1) % RING;
            end
            return res;
        end
        if (bat) begin
            s = base_step_reg;
            if (fill > RING / 2) begin
                s = s * SCALE_UP / SCALE_DIV;
            end else if (fill < DEF_LOW_WATER) begin
                s = s * SCALE_DOWN / SCALE_DIV;
            end
            step_now = (s > STEP_MAX) ? STEP_MAX : int'(s);
        end
        if (fill < 2) begin
            res.smp   = held_smp;
            res.under = 1'b1;
            return res;
        end
        a    = $signed(ring_copy[rd_ptr]);
        b    = $signed(ring_copy[(rd_ptr + 1) % RING]);
        prod = longint'(b - a) * longint'(frac_pos);
        t    = (prod < 0) ? -((-prod) >> FB) : (prod >> FB);
        r    = a + int'(t);
        held_smp = r[SAMPLE_W-1:0];
        res.smp  = held_smp;
        acc   = frac_pos + step_now;
        whole = acc >> FB;
        avail = fill - 1;
        if (whole <= avail) begin
            rd_ptr   = (rd_ptr + whole) % RING;
            frac_pos = acc & (ONE_POS - 1);
        end else begin
            rd_ptr   = (rd_ptr + avail) % RING;
            frac_pos = 0;
        end
        return res;
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return SAMPLE_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // call at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic act, input logic [SAMPLE_W-1:0] smp, input logic bat,
                             input logic typed = 1'b0, input t_out_exp typed_word = '0);
        t_out_exp           pred;
        logic [TUSER_W-1:0] usr;
        usr            = '0;
        usr[TU_ACTION] = act;
        usr[TU_BATCH]  = bat;
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= smp;
        s_user  <= usr;
        do @(posedge i_clk); while (!s_ready);
        pred = predict_word(act, smp, bat);
        out_word_q.push_back(typed ? typed_word : pred);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (out_word_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_base_step(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= value[STEP_W-1:0];
        do @(posedge i_clk); while (!cfg_ready);
        base_step_reg = value & STEP_MAX;
        n_cfg_writes++;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_traffic(input int n_items);
        int done;
        int pushes;
        int renders;
        done = 0;
        while (done < n_items) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_word(1'($urandom_range(0, 1)), rand_sample(),
                              1'($urandom_range(0, 1)));
                    done++;
                end
                1: begin
                    renders = $urandom_range(1, 3);
                    repeat (renders) send_word(ACT_RENDER, rand_sample(), 1'b0);
                    done += renders;
                end
                default: begin
                    pushes  = $urandom_range(1, 4 + 4 * (base_step_reg >> FB));
                    renders = $urandom_range(1, 4);
                    repeat (pushes) send_word(ACT_PUSH, rand_sample(),
                                              1'($urandom_range(0, 1)));
                    send_word(ACT_RENDER, rand_sample(), 1'b1);
                    repeat (renders - 1) send_word(ACT_RENDER, rand_sample(), 1'b0);
                    done += pushes + renders;
                end
            endcase
        end
    endtask

    always @(negedge i_clk) begin
        m_ready <= ($urandom_range(0, 99) >= r_idle_pct);
    end

    always @(posedge i_clk) begin
        t_out_exp got;
        t_out_exp want;
        if (i_rst_n && m_valid && m_ready) begin
            got = '{m_data, m_user[TU_UNDERRUN], m_user[TU_DROPPED]};
            if (out_word_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected out word, expected none, actual sample %h underrun %b dropped %b",
                         $time, got.smp, got.under, got.drop);
            end else begin
                want = out_word_q.pop_front();
                n_checked++;
                if (got.under) n_underruns++;
                if (got.drop) n_drops++;
                if (got.smp !== want.smp || got.under !== want.under
                    || got.drop !== want.drop) begin
                    n_errors++;
                    $display("%0t: out word mismatch, expected sample %h underrun %b dropped %b,",
                             $time, want.smp, want.under, want.drop);
                    $display("    actual sample %h underrun %b dropped %b",
                             got.smp, got.under, got.drop);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        wr_ptr        = 0;
        rd_ptr        = 0;
        frac_pos      = 0;
        step_now      = ONE_POS;
        base_step_reg = ONE_POS;
        held_smp      = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        s_idle_pct = 28;
        r_idle_pct = 84;
        @(negedge i_clk);
        for (int i = 0; i < N_DIR; i++) begin
            send_word(DIR_ROWS[i].act, DIR_ROWS[i].smp, DIR_ROWS[i].bat,
                      DIR_ROWS[i].typed, DIR_ROWS[i].word);
        end

        for (int p = 0; p < N_PHASE; p++) begin
            settle();
            case (p / 3)
                0: begin
                    s_idle_pct = 28;
                    r_idle_pct = 84;
                end
                1: begin
                    s_idle_pct = 84;
                    r_idle_pct = 28;
                end
                default: begin
                    s_idle_pct = 0;
                    r_idle_pct = 0;
                end
            endcase
            write_base_step(PHASE_STEP[p] != 0 ? PHASE_STEP[p] : $urandom_range(1, STEP_MAX));
            run_traffic(PHASE_ITEMS);
        end

        settle();
        repeat (8) @(negedge i_clk);

        $display("sent %0d input words, checked %0d output words", n_sent, n_checked);
        $display("seen %0d underruns and %0d drops over %0d base_step writes",
                 n_underruns, n_drops, n_cfg_writes);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
src/alr_pkg.sv
src/alr_ram.sv
src/alr_step_calc.sv
src/alr_interp.sv
src/adaptive_linear_resampler_core.sv
tb/tb_adaptive_linear_resampler_core.sv
